### rtl/pqmm_pkg.sv
// shared types and codes for the min/max priority queue
`timescale 1ns / 1ps
package pqmm_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;
  localparam logic [1:0] CMD_ERASE  = 2'd3;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOT_MORE = 3'd4;

  localparam int unsigned COUNT_BITS = 5;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture input beat
    logic scan_start;  // scan index to 0, clear found and best
    logic scan_step;   // compare entry at scan index, advance
    logic write_new;   // write inserted entry at tail
    logic write_prio;  // write new prio at found position
    logic shift_start; // index to drop position + 1
    logic shift_step;  // copy entry idx+1 into idx, advance
    logic dec_total;   // count down after a drop
    logic out_load;    // capture result into output register
  } pqmm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       scan_done;  // scan index reached the count
    logic       found;      // key match seen
    logic       shift_done; // shift reached the end
    logic       full;
    logic       empty;
    logic       more_urgent; // new prio beats held prio at found position
  } pqmm_sts_t;

endpackage

### rtl/pqmm_ram.sv
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
module pqmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata <= mem_r[raddr];
  end
endmodule

### rtl/pqmm_datapath.sv
// entry storage, scan and shift datapath of the priority queue
`timescale 1ns / 1ps
module pqmm_datapath
  import pqmm_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int KEY_BITS  = 16,
  parameter int PRIO_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        serve_highest,
  input  logic [1:0]                  in_cmd,
  input  logic [KEY_BITS-1:0]         in_key,
  input  logic signed [PRIO_BITS-1:0] in_prio,
  input  pqmm_cmd_t                   ctl,
  output pqmm_sts_t                   sts,
  input  logic [2:0]                  status_in,
  output logic [2:0]                  out_status,
  output logic                        out_top_valid,
  output logic [KEY_BITS-1:0]         out_top_key,
  output logic signed [PRIO_BITS-1:0] out_top_prio,
  output logic [COUNT_BITS-1:0]       out_count
);
  localparam int AW = $clog2(DEPTH);
  localparam int TW = $clog2(DEPTH + 1);

  logic [1:0]                  cmd_r;
  logic [KEY_BITS-1:0]         key_r;
  logic signed [PRIO_BITS-1:0] prio_r;
  logic [TW-1:0]               total_r;
  logic [TW-1:0]               idx_r;      // address presented to ram
  logic                        rd_ok_r;    // ram data belongs to rd_idx_r
  logic [AW-1:0]               rd_idx_r;
  logic                        found_r;
  logic [AW-1:0]               pos_r;
  logic signed [PRIO_BITS-1:0] pos_prio_r;
  logic                        best_v_r;
  logic [KEY_BITS-1:0]         best_key_r;
  logic signed [PRIO_BITS-1:0] best_prio_r;
  logic [AW-1:0]               best_idx_r;

  logic [KEY_BITS-1:0]         rk;
  logic signed [PRIO_BITS-1:0] rp;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [KEY_BITS-1:0]         wkey;
  logic signed [PRIO_BITS-1:0] wprio;
  logic                        beats;
  logic [AW-1:0]               drop_pos;

  // remove drops the top entry, erase drops the matched one
  assign drop_pos = (cmd_r == CMD_REMOVE) ? best_idx_r : pos_r;

  // shift moves idx+1 into idx: write address is read address - 1
  always_comb begin
    we    = 1'b0;
    waddr = rd_idx_r;
    wkey  = rk;
    wprio = rp;
    if (ctl.write_new) begin
      we = 1'b1; waddr = total_r[AW-1:0]; wkey = key_r; wprio = prio_r;
    end else if (ctl.write_prio) begin
      we = 1'b1; waddr = pos_r; wkey = key_r; wprio = prio_r;
    end else if (ctl.shift_step && rd_ok_r) begin
      we = 1'b1; waddr = rd_idx_r - AW'(1);
    end
  end

  pqmm_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_keys (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wkey),
    .raddr(idx_r[AW-1:0]), .rdata(rk));
  pqmm_ram #(.WIDTH(PRIO_BITS), .DEPTH(DEPTH)) u_prios (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wprio),
    .raddr(idx_r[AW-1:0]), .rdata(rp));

  assign beats = serve_highest ? (rp > best_prio_r) : (rp < best_prio_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      rd_ok_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (ctl.load) begin
        cmd_r  <= in_cmd;
        key_r  <= in_key;
        prio_r <= in_prio;
      end
      if (ctl.write_new) total_r <= total_r + TW'(1);
      else if (ctl.dec_total) total_r <= total_r - TW'(1);
      if (ctl.scan_start) begin
        idx_r    <= '0;
        rd_ok_r  <= 1'b0;
        found_r  <= 1'b0;
        best_v_r <= 1'b0;
      end else if (ctl.shift_start) begin
        // first read one past the dropped slot
        idx_r   <= TW'(drop_pos) + TW'(1);
        rd_ok_r <= 1'b0;
      end else if (ctl.scan_step || ctl.shift_step) begin
        if (idx_r < total_r) begin
          idx_r    <= idx_r + TW'(1);
          rd_ok_r  <= 1'b1;
          rd_idx_r <= idx_r[AW-1:0];
        end else begin
          rd_ok_r <= 1'b0;
        end
        if (ctl.scan_step && rd_ok_r) begin
          if (!found_r && rk == key_r) begin
            found_r    <= 1'b1;
            pos_r      <= rd_idx_r;
            pos_prio_r <= rp;
          end
          // strict compare keeps the earliest arrival on ties
          if (!best_v_r || beats) begin
            best_v_r    <= 1'b1;
            best_key_r  <= rk;
            best_prio_r <= rp;
            best_idx_r  <= rd_idx_r;
          end
        end
      end else begin
        rd_ok_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_status    <= status_in;
      out_top_valid <= best_v_r;
      out_top_key   <= best_v_r ? best_key_r : '0;
      out_top_prio  <= best_v_r ? best_prio_r : '0;
      out_count     <= COUNT_BITS'(total_r);
    end
  end

  assign sts.cmd         = cmd_r;
  assign sts.scan_done   = (idx_r >= total_r) && !rd_ok_r;
  assign sts.found       = found_r;
  assign sts.shift_done  = (idx_r >= total_r) && !rd_ok_r;
  assign sts.full        = (total_r >= TW'(DEPTH));
  assign sts.empty       = (total_r == '0);
  assign sts.more_urgent = serve_highest ? (prio_r > pos_prio_r) : (prio_r < pos_prio_r);
endmodule

### rtl/pqmm_ctrl.sv
// sequencing state machine of the priority queue
`timescale 1ns / 1ps
module pqmm_ctrl
  import pqmm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  pqmm_sts_t sts,
  output pqmm_cmd_t ctl,
  output logic [2:0] status
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN1, S_ACT, S_SHIFT, S_SCAN2} state_t;
  state_t     state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] status_r, status_nxt;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign status    = status_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    ctl           = '0;
    case (state_r)
      S_IDLE: if (in_valid && !in_stall) begin
        ctl.load       = 1'b1;
        ctl.scan_start = 1'b1;
        state_nxt      = S_SCAN1;
      end
      S_SCAN1: begin
        if (sts.scan_done) state_nxt = S_ACT;
        else ctl.scan_step = 1'b1;
      end
      S_ACT: begin
        status_nxt     = ST_DONE;
        state_nxt      = S_SCAN2;
        ctl.scan_start = 1'b1;
        case (sts.cmd)
          CMD_INSERT: begin
            if (sts.full) status_nxt = ST_FULL;
            else ctl.write_new = 1'b1;
          end
          CMD_REMOVE: begin
            if (sts.empty) status_nxt = ST_EMPTY;
            else begin
              ctl.scan_start  = 1'b0;
              ctl.shift_start = 1'b1;
              state_nxt       = S_SHIFT;
            end
          end
          CMD_UPDATE: begin
            if (!sts.found) status_nxt = ST_NOT_FOUND;
            else if (!sts.more_urgent) status_nxt = ST_NOT_MORE;
            else ctl.write_prio = 1'b1;
          end
          default: begin
            if (!sts.found) status_nxt = ST_NOT_FOUND;
            else begin
              ctl.scan_start  = 1'b0;
              ctl.shift_start = 1'b1;
              state_nxt       = S_SHIFT;
            end
          end
        endcase
      end
      S_SHIFT: begin
        if (sts.shift_done) begin
          ctl.dec_total  = 1'b1;
          ctl.scan_start = 1'b1;
          state_nxt      = S_SCAN2;
        end else begin
          ctl.shift_step = 1'b1;
        end
      end
      S_SCAN2: begin
        if (sts.scan_done) begin
          ctl.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      status_r    <= ST_DONE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
  end
endmodule

### rtl/priority_queue_min_max.sv
// top level of the min/max priority queue with decrease-key
// an accepted beat runs two entry scans over one ram read port before out_valid;
// a drop adds a shift pass from the dropped slot up to the count
// throughput: one beat at a time; the next beat can be taken in the same cycle as the result is taken
// reset: synchronous active-low rst_n empties the queue and sets serve_highest to 1
// entry rams are not cleared; only slots below the count are read
`timescale 1ns / 1ps
module priority_queue_min_max
  import pqmm_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int KEY_BITS  = 16,
  parameter int PRIO_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_cmd,
  input  logic [KEY_BITS-1:0]         in_key,
  input  logic signed [PRIO_BITS-1:0] in_prio,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_status,
  output logic                        out_top_valid,
  output logic [KEY_BITS-1:0]         out_top_key,
  output logic signed [PRIO_BITS-1:0] out_top_prio,
  output logic [COUNT_BITS-1:0]       out_count
);
  logic      serve_highest_r;
  pqmm_cmd_t ctl;
  pqmm_sts_t sts;
  logic [2:0] status;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) serve_highest_r <= 1'b1;
    else if (cfg_we) serve_highest_r <= cfg_wdata;
  end

  pqmm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .ctl(ctl),
    .status(status));

  pqmm_datapath #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS), .PRIO_BITS(PRIO_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .serve_highest(serve_highest_r),
    .in_cmd(in_cmd), .in_key(in_key), .in_prio(in_prio),
    .ctl(ctl), .sts(sts), .status_in(status),
    .out_status(out_status), .out_top_valid(out_top_valid),
    .out_top_key(out_top_key), .out_top_prio(out_top_prio), .out_count(out_count));
endmodule
